/* hdl/pse_pkg.sv */
// postfix_stack_evaluator shared types and constants
// no dependencies
package pse_pkg;

	localparam int unsigned DataW = 32;

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_OP   = 2'd1,
		KIND_END  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4,
		OP_POW = 3'd5,
		OP_RS6 = 3'd6,
		OP_RS7 = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_DIV0  = 3'd1,
		ST_ZPZ   = 3'd2,
		ST_UNDER = 3'd3,
		ST_OVER  = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		AU_MUL = 2'd0,
		AU_DIV = 2'd1,
		AU_POW = 2'd2
	} au_mode_t;

	typedef struct packed {
		logic     go;
		au_mode_t mode;
	} au_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_R,
		S_WT_R,
		S_RD_L,
		S_WT_L,
		S_EXEC,
		S_ARITH,
		S_WB,
		S_END_RD,
		S_END_WT,
		S_DONE
	} fsm_t;

endpackage

/* hdl/pse_arith.sv */
// shared iterative unit: shift-add multiply, restoring divide, square-multiply power
// depends on pse_pkg
module pse_arith (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pse_pkg::au_ctl_t              ctl,
	input  logic [pse_pkg::DataW-1:0]     a,
	input  logic [pse_pkg::DataW-1:0]     b,
	output logic                          done,
	output logic [pse_pkg::DataW-1:0]     prod,
	output logic [pse_pkg::DataW-1:0]     quo,
	output logic [pse_pkg::DataW-1:0]     rem
);
	import pse_pkg::*;

	// one bit of multiplier or dividend per cycle
	logic             busy_q;
	au_mode_t         mode_q;
	logic [5:0]       cnt_q;
	logic [DataW-1:0] acc_q;
	logic [DataW-1:0] mcand_q;
	logic [DataW-1:0] mplier_q;
	logic [DataW-1:0] dvs_q;
	// power: base, exponent, and multiply phase
	logic [DataW-1:0] base_q;
	logic [DataW-1:0] expo_q;
	logic [DataW-1:0] pacc_q;
	logic [1:0]       pph_q;
	logic [DataW:0]   trial;
	logic [DataW-1:0] rem_sh;

	assign rem_sh = {acc_q[DataW-2:0], mplier_q[DataW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

	assign prod = acc_q;
	assign quo  = mplier_q;
	assign rem  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			mode_q <= AU_MUL;
			cnt_q  <= '0;
			pph_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.go && !busy_q) begin
				busy_q <= 1'b1;
				mode_q <= ctl.mode;
				cnt_q  <= '0;
				pph_q  <= '0;
			end else if (busy_q) begin
				unique case (mode_q)
					AU_MUL, AU_DIV: begin
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'd31) begin
							busy_q <= 1'b0;
							done   <= 1'b1;
						end
					end
					AU_POW: begin
						// phases: 0 decide, 1 acc*=base running, 2 base*=base running
						if (pph_q == 2'd0) begin
							if (expo_q == '0) begin
								busy_q <= 1'b0;
								done   <= 1'b1;
							end else begin
								pph_q <= expo_q[0] ? 2'd1 : 2'd2;
								cnt_q <= '0;
							end
						end else begin
							if (cnt_q == 6'd31) begin
								cnt_q <= '0;
								pph_q <= (pph_q == 2'd1) ? 2'd2 : 2'd0;
							end else begin
								cnt_q <= cnt_q + 6'd1;
							end
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go && !busy_q) begin
			unique case (ctl.mode)
				AU_MUL: begin
					acc_q    <= '0;
					mcand_q  <= a;
					mplier_q <= b;
				end
				AU_DIV: begin
					acc_q    <= '0;
					mplier_q <= a;
					dvs_q    <= b;
				end
				default: begin
					base_q <= a;
					expo_q <= b;
					pacc_q <= {{(DataW-1){1'b0}}, 1'b1};
				end
			endcase
		end else if (busy_q) begin
			unique case (mode_q)
				AU_MUL: begin
					acc_q    <= (acc_q << 1) + (mplier_q[DataW-1] ? mcand_q : '0);
					mplier_q <= mplier_q << 1;
				end
				AU_DIV: begin
					if (!trial[DataW]) acc_q <= trial[DataW-1:0];
					else acc_q <= rem_sh;
					mplier_q <= {mplier_q[DataW-2:0], ~trial[DataW]};
				end
				AU_POW: begin
					if (pph_q == 2'd0) begin
						if (expo_q != '0) begin
							acc_q    <= '0;
							mcand_q  <= expo_q[0] ? pacc_q : base_q;
							mplier_q <= base_q;
						end else begin
							acc_q <= pacc_q;
						end
					end else begin
						if (cnt_q == 6'd31) begin
							if (pph_q == 2'd1) begin
								pacc_q   <= (acc_q << 1) + (mplier_q[DataW-1] ? mcand_q : '0);
								acc_q    <= '0;
								mcand_q  <= base_q;
								mplier_q <= base_q;
							end else begin
								base_q <= (acc_q << 1) + (mplier_q[DataW-1] ? mcand_q : '0);
								expo_q <= expo_q >> 1;
							end
						end else begin
							acc_q    <= (acc_q << 1) + (mplier_q[DataW-1] ? mcand_q : '0);
							mplier_q <= mplier_q << 1;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* hdl/postfix_stack_evaluator_core.sv */
// postfix evaluator top level: operand stack memory and sequencer
// depends on pse_pkg and pse_arith
//
// Pulse start while busy is low; exactly one result strobe follows per item and
// cannot be stalled. Add and subtract are done in the sequencer; multiply, divide and
// remainder run on the one-bit-a-cycle shared unit, and power runs square-and-multiply
// on that same unit. Stack reads go through a registered memory port.
module postfix_stack_evaluator_core #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [30:0] operand_value,
	input  logic [2:0]  operator_code,
	output logic        result_valid,
	output logic signed [31:0] result_value,
	output logic [2:0]  status,
	output logic [4:0]  stack_count
);
	import pse_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

	logic [DataW-1:0] mem [STACK_DEPTH];
	logic [DataW-1:0] rd_q;
	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [DataW-1:0] wdata;

	fsm_t state_q, state_d;
	logic [PW-1:0]    sp_q;
	kind_t            kind_q;
	op_t              op_q;
	logic [DataW-1:0] r_q, l_q, res_q;
	status_t          st_q;

	au_ctl_t          au_ctl;
	logic             au_done;
	logic [DataW-1:0] au_a, au_b, au_prod, au_quo, au_rem;
	logic [DataW-1:0] mag_l, mag_r, sum;
	logic             full;

	assign mag_l = l_q[DataW-1] ? (~l_q + 1'b1) : l_q;
	assign mag_r = r_q[DataW-1] ? (~r_q + 1'b1) : r_q;
	assign full  = (sp_q >= PW'(STACK_DEPTH));

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	pse_arith u_arith (
		.clk(clk), .arst_n(arst_n), .ctl(au_ctl), .a(au_a), .b(au_b),
		.done(au_done), .prod(au_prod), .quo(au_quo), .rem(au_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				unique case (kind_t'(kind))
					KIND_PUSH: state_d = S_DONE;
					KIND_OP:   state_d = (operator_code > 3'(OP_POW) || sp_q == '0)
						? S_DONE : S_RD_R;
					KIND_END:  state_d = (sp_q == '0) ? S_DONE : S_END_RD;
					default:   state_d = S_DONE;
				endcase
			end
			S_RD_R:   state_d = S_WT_R;
			S_WT_R:   state_d = (sp_q == '0) ? S_DONE : S_RD_L;
			S_RD_L:   state_d = S_WT_L;
			S_WT_L:   state_d = S_EXEC;
			S_EXEC: begin
				priority if ((op_q == OP_DIV || op_q == OP_REM) && r_q == '0)
					state_d = S_DONE;
				else if (op_q == OP_POW && l_q == '0 && r_q == '0) state_d = S_DONE;
				else if (op_q == OP_ADD || op_q == OP_SUB) state_d = S_WB;
				else if (op_q == OP_POW && r_q[DataW-1]) state_d = S_WB;
				else state_d = S_ARITH;
			end
			S_ARITH:  if (au_done) state_d = S_WB;
			S_WB:     state_d = S_DONE;
			S_END_RD: state_d = S_END_WT;
			S_END_WT: state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy  = (state_q != S_IDLE);
		au_ctl.go   = (state_q == S_EXEC) && (state_d == S_ARITH);
		au_ctl.mode = (op_q == OP_MUL) ? AU_MUL : (op_q == OP_POW) ? AU_POW : AU_DIV;
		au_a  = (op_q == OP_DIV || op_q == OP_REM) ? mag_l : l_q;
		au_b  = (op_q == OP_DIV || op_q == OP_REM) ? mag_r : r_q;
		// the pointer has already stepped down past the entry being read
		raddr = AW'(sp_q);
		we    = 1'b0;
		waddr = AW'(sp_q);
		wdata = res_q;
		sum   = (op_q == OP_SUB) ? (l_q - r_q) : (l_q + r_q);
		if (state_q == S_IDLE && start && kind_t'(kind) == KIND_PUSH && !full) begin
			we    = 1'b1;
			wdata = {1'b0, operand_value};
		end else if (state_q == S_WB) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sp_q         <= '0;
			st_q         <= ST_OK;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= (state_q == S_DONE);
			if (state_q == S_IDLE && start) begin
				st_q <= ST_OK;
				priority if (kind_t'(kind) == KIND_PUSH) begin
					if (full) st_q <= ST_OVER;
					else sp_q <= sp_q + 1'b1;
				end else if (kind_t'(kind) == KIND_OP && operator_code <= 3'(OP_POW)) begin
					if (sp_q == '0) st_q <= ST_UNDER;
					else sp_q <= sp_q - 1'b1;
				end else if (kind_t'(kind) == KIND_END) begin
					if (sp_q == '0) st_q <= ST_EMPTY;
					else sp_q <= sp_q - 1'b1;
				end
			end
			if (state_q == S_WT_R) begin
				if (sp_q == '0) st_q <= ST_UNDER;
				else sp_q <= sp_q - 1'b1;
			end
			if (state_q == S_EXEC) begin
				if ((op_q == OP_DIV || op_q == OP_REM) && r_q == '0) st_q <= ST_DIV0;
				else if (op_q == OP_POW && l_q == '0 && r_q == '0) st_q <= ST_ZPZ;
			end
			if (state_q == S_WB) sp_q <= sp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			kind_q <= kind_t'(kind);
			op_q   <= op_t'(operator_code);
			res_q  <= '0;
		end
		if (state_q == S_WT_R) r_q <= rd_q;
		if (state_q == S_WT_L) l_q <= rd_q;
		if (state_q == S_EXEC) begin
			if (op_q == OP_POW) res_q <= {{(DataW-1){1'b0}}, 1'b1};
			else res_q <= sum;
		end
		if (state_q == S_ARITH && au_done) begin
			unique case (op_q)
				OP_DIV:  res_q <= (l_q[DataW-1] ^ r_q[DataW-1]) ? (~au_quo + 1'b1) : au_quo;
				OP_REM:  res_q <= l_q[DataW-1] ? (~au_rem + 1'b1) : au_rem;
				default: res_q <= au_prod;
			endcase
		end
		if (state_q == S_END_WT) res_q <= rd_q;
		if (state_q == S_DONE) begin
			result_value <= (kind_q == KIND_END && st_q == ST_OK) ? res_q : '0;
			status       <= st_q;
			stack_count  <= 5'(sp_q);
		end
	end

endmodule

/* hdl/pse_checker.sv */
// port-level checks for postfix_stack_evaluator_core, bound to the top level
// depends on pse_pkg
module pse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [2:0]  status,
	input logic [4:0]  stack_count,
	input logic [31:0] result_value
);
	import pse_pkg::*;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after start");
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe repeated");
	a_idle_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("strobe while busy");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= 3'(ST_EMPTY)) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != 3'(ST_OK) |-> result_value == '0) else $error("value on error");

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .status(status), .stack_count(stack_count),
	.result_value(result_value)
);
